// ----- hw/rtl/bts_pkg.sv -----
package bts_pkg;

   // Texture limits.
   localparam int MAX_WIDTH   = 128;
   localparam int MAX_HEIGHT  = 128;
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

   // Field widths fixed by the interface.
   localparam int ADDR_BITS  = 14;
   localparam int TEXEL_BITS = 32;
   localparam int COORD_BITS = 16;
   localparam int DIM_BITS   = 8;
   localparam int FRAC_BITS  = 8;
   localparam int CHAN_BITS  = 8;
   localparam int NUM_CHANS  = TEXEL_BITS / CHAN_BITS;

   // Derived widths.
   localparam int X_BITS      = $clog2(MAX_WIDTH);
   localparam int Y_BITS      = $clog2(MAX_HEIGHT);
   localparam int WEIGHT_BITS = FRAC_BITS + 1;
   localparam int PROD_BITS   = CHAN_BITS + WEIGHT_BITS;
   localparam int SUM_BITS    = PROD_BITS + 2;

   // Item codes.
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Register indexes.
   localparam logic CSR_IDX_WIDTH  = 1'b0;
   localparam logic CSR_IDX_HEIGHT = 1'b1;

   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [TEXEL_BITS-1:0] texel_type;

   typedef struct packed {
      logic      en;
      addr_type  addr;
      texel_type data;
   } store_write_type;

   // Four neighbors: 00 = (x, y), 01 = (x+1, y), 10 = (x, y+1), 11 = (x+1, y+1).
   typedef struct packed {
      addr_type a00;
      addr_type a01;
      addr_type a10;
      addr_type a11;
   } quad_addr_type;

   typedef struct packed {
      texel_type t00;
      texel_type t01;
      texel_type t10;
      texel_type t11;
   } quad_texel_type;

endpackage

// ----- hw/rtl/bilinear_texel_sampler_core.sv -----
// Bilinear texel sampler over an RGBA8 texture.
// An item is taken at a rising edge where start is high and busy is low. With
// req_opcode low the item writes req_texel_value to the texel store at
// req_texel_index and gives no result. With req_opcode high the item samples at
// the signed 8.8 coordinate (req_coord_x, req_coord_y) and gives one result.
// The result shows on rsp_pixel for exactly one cycle with rsp_valid high; a
// sample outside the texture gives zero. One item is taken every cycle: five
// pipeline stages (coordinate split, row base and weight multiply, store read,
// channel multiply, sum) each hold one item, and busy stays low. A sample sees
// every write taken before it. The receiver cannot stall, so the pipeline
// never holds. The csr_ port writes image_width (index 0) and image_height
// (index 1); the user must write them only while no item is in flight, which
// the block itself does not enforce. Reset clears the pipeline and sets both to
// zero; the texel store keeps undefined contents until written.
module bilinear_texel_sampler_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic                                  req_opcode,
   input  logic [bts_pkg::ADDR_BITS-1:0]         req_texel_index,
   input  logic [bts_pkg::TEXEL_BITS-1:0]        req_texel_value,
   input  logic signed [bts_pkg::COORD_BITS-1:0] req_coord_x,
   input  logic signed [bts_pkg::COORD_BITS-1:0] req_coord_y,
   input  logic                                  csr_we,
   input  logic                                  csr_index,
   input  logic [bts_pkg::DIM_BITS-1:0]          csr_wdata,
   output logic                                  rsp_valid,
   output logic [bts_pkg::TEXEL_BITS-1:0]        rsp_pixel
);
   import bts_pkg::*;

   logic [DIM_BITS-1:0] width_ff, height_ff;
   logic [DIM_BITS-1:0] width_eff, height_eff;

   // Stage 1 signals.
   logic                   valid1_ff, op1_ff, inside1_ff;
   addr_type               waddr1_ff;
   texel_type              wdata1_ff;
   logic [X_BITS-1:0]      px1_ff, pxn1_ff;
   logic [Y_BITS-1:0]      py1_ff, pyn1_ff;
   logic [FRAC_BITS-1:0]   fx1_ff, fy1_ff;
   logic                   inside1_in;
   logic [X_BITS-1:0]      px_in, pxn_in;
   logic [Y_BITS-1:0]      py_in, pyn_in;
   logic [DIM_BITS-1:0]    px_inc, py_inc, pxn_full, pyn_full;

   // Stage 2 signals.
   logic                   valid2_ff, op2_ff, inside2_ff;
   addr_type               waddr2_ff;
   texel_type              wdata2_ff;
   logic [X_BITS-1:0]      px2_ff, pxn2_ff;
   addr_type               row0_ff, row1_ff;
   logic [WEIGHT_BITS-1:0] wt2_ff [4];
   logic [Y_BITS+DIM_BITS-1:0] row0_in, row1_in;
   logic [WEIGHT_BITS-1:0] inv_fx, inv_fy;
   logic [2*WEIGHT_BITS-1:0] wprod [4];

   // Stage 3 signals.
   logic                   valid3_ff, sample3_ff, inside3_ff;
   logic [WEIGHT_BITS-1:0] wt3_ff [4];
   store_write_type        store_wr;
   quad_addr_type          store_addr;
   quad_texel_type         store_data;
   texel_type              texels [4];

   // Stage 4 signals.
   logic                   sample4_ff, inside4_ff;
   logic [PROD_BITS-1:0]   prod_ff [4][NUM_CHANS];
   logic [PROD_BITS-1:0]   prod_in [4][NUM_CHANS];

   // Stage 5 signals.
   logic                   rsp_valid_ff;
   texel_type              rsp_pixel_ff, rsp_pixel_in;
   logic [SUM_BITS-1:0]    chan_sum [NUM_CHANS];

   assign busy = 1'b0;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= '0;
         height_ff <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IDX_WIDTH:  width_ff  <= csr_wdata;
            CSR_IDX_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign width_eff  = (width_ff > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : width_ff;
   assign height_eff = (height_ff > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : height_ff;

   // Stage 1: range check, integer and fraction split, clamped right/lower neighbor.
   always_comb begin
      inside1_in = !req_coord_x[COORD_BITS-1] && !req_coord_y[COORD_BITS-1]
                   && ({1'b0, req_coord_x[COORD_BITS-2:0]} < {width_eff, FRAC_BITS'(0)})
                   && ({1'b0, req_coord_y[COORD_BITS-2:0]} < {height_eff, FRAC_BITS'(0)});
      px_in    = req_coord_x[FRAC_BITS +: X_BITS];
      py_in    = req_coord_y[FRAC_BITS +: Y_BITS];
      px_inc   = DIM_BITS'(px_in) + DIM_BITS'(1);
      py_inc   = DIM_BITS'(py_in) + DIM_BITS'(1);
      pxn_full = (px_inc < width_eff) ? px_inc : width_eff - DIM_BITS'(1);
      pyn_full = (py_inc < height_eff) ? py_inc : height_eff - DIM_BITS'(1);
      pxn_in   = pxn_full[X_BITS-1:0];
      pyn_in   = pyn_full[Y_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else begin
         valid1_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      op1_ff     <= req_opcode;
      inside1_ff <= inside1_in;
      waddr1_ff  <= req_texel_index;
      wdata1_ff  <= req_texel_value;
      px1_ff     <= px_in;
      pxn1_ff    <= pxn_in;
      py1_ff     <= py_in;
      pyn1_ff    <= pyn_in;
      fx1_ff     <= req_coord_x[FRAC_BITS-1:0];
      fy1_ff     <= req_coord_y[FRAC_BITS-1:0];
   end

   // Stage 2: row base addresses and the four blend weights.
   always_comb begin
      row0_in  = py1_ff * width_eff;
      row1_in  = pyn1_ff * width_eff;
      inv_fx   = WEIGHT_BITS'(1 << FRAC_BITS) - WEIGHT_BITS'(fx1_ff);
      inv_fy   = WEIGHT_BITS'(1 << FRAC_BITS) - WEIGHT_BITS'(fy1_ff);
      wprod[0] = inv_fx * inv_fy;
      wprod[1] = WEIGHT_BITS'(fx1_ff) * inv_fy;
      wprod[2] = inv_fx * WEIGHT_BITS'(fy1_ff);
      wprod[3] = WEIGHT_BITS'(fx1_ff) * WEIGHT_BITS'(fy1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid2_ff <= 1'b0;
      end else begin
         valid2_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      op2_ff     <= op1_ff;
      inside2_ff <= inside1_ff;
      waddr2_ff  <= waddr1_ff;
      wdata2_ff  <= wdata1_ff;
      px2_ff     <= px1_ff;
      pxn2_ff    <= pxn1_ff;
      row0_ff    <= row0_in[ADDR_BITS-1:0];
      row1_ff    <= row1_in[ADDR_BITS-1:0];
      for (int i = 0; i < 4; i++) begin
         wt2_ff[i] <= wprod[i][FRAC_BITS +: WEIGHT_BITS];
      end
   end

   // Stage 3: store access. Writes land here too, so a later sample sees them.
   always_comb begin
      store_wr.en    = valid2_ff && (op2_ff == OP_WRITE);
      store_wr.addr  = waddr2_ff;
      store_wr.data  = wdata2_ff;
      store_addr.a00 = row0_ff + ADDR_BITS'(px2_ff);
      store_addr.a01 = row0_ff + ADDR_BITS'(pxn2_ff);
      store_addr.a10 = row1_ff + ADDR_BITS'(px2_ff);
      store_addr.a11 = row1_ff + ADDR_BITS'(pxn2_ff);
   end

   bts_texel_store u_store (
      .clock   (clock),
      .wr      (store_wr),
      .rd_addr (store_addr),
      .rd_data (store_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid3_ff <= 1'b0;
      end else begin
         valid3_ff <= valid2_ff;
      end
   end

   always_ff @(posedge clock) begin
      sample3_ff <= (op2_ff == OP_SAMPLE);
      inside3_ff <= inside2_ff;
      wt3_ff     <= wt2_ff;
   end

   // Stage 4: texel channel times weight.
   assign texels[0] = store_data.t00;
   assign texels[1] = store_data.t01;
   assign texels[2] = store_data.t10;
   assign texels[3] = store_data.t11;

   always_comb begin
      for (int t = 0; t < 4; t++) begin
         for (int c = 0; c < NUM_CHANS; c++) begin
            prod_in[t][c] = texels[t][c*CHAN_BITS +: CHAN_BITS] * wt3_ff[t];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample4_ff <= 1'b0;
      end else begin
         sample4_ff <= valid3_ff && sample3_ff;
      end
   end

   always_ff @(posedge clock) begin
      inside4_ff <= inside3_ff;
      prod_ff    <= prod_in;
   end

   // Stage 5: per-channel sum and pack.
   always_comb begin
      rsp_pixel_in = '0;
      for (int c = 0; c < NUM_CHANS; c++) begin
         chan_sum[c] = SUM_BITS'(prod_ff[0][c]) + SUM_BITS'(prod_ff[1][c])
                     + SUM_BITS'(prod_ff[2][c]) + SUM_BITS'(prod_ff[3][c]);
         if (inside4_ff) begin
            rsp_pixel_in[c*CHAN_BITS +: CHAN_BITS] = chan_sum[c][FRAC_BITS +: CHAN_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= sample4_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_pixel_ff <= rsp_pixel_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;

endmodule

// ----- hw/rtl/bts_texel_store.sv -----
module bts_texel_store (
   input  logic                     clock,
   input  bts_pkg::store_write_type wr,
   input  bts_pkg::quad_addr_type   rd_addr,
   output bts_pkg::quad_texel_type  rd_data
);
   import bts_pkg::*;

   // Two copies of the texture, each with two read ports: the upper copy serves
   // the top row of the neighborhood, the lower copy the bottom row.
   texel_type mem_top [STORE_DEPTH];
   texel_type mem_bot [STORE_DEPTH];

   texel_type t00_ff, t01_ff, t10_ff, t11_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_top[wr.addr] <= wr.data;
      end
      t00_ff <= mem_top[rd_addr.a00];
      t01_ff <= mem_top[rd_addr.a01];
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_bot[wr.addr] <= wr.data;
      end
      t10_ff <= mem_bot[rd_addr.a10];
      t11_ff <= mem_bot[rd_addr.a11];
   end

   assign rd_data.t00 = t00_ff;
   assign rd_data.t01 = t01_ff;
   assign rd_data.t10 = t10_ff;
   assign rd_data.t11 = t11_ff;

endmodule

// ----- hw/rtl/bts_checker.sv -----
module bts_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic                                  req_opcode,
   input logic signed [bts_pkg::COORD_BITS-1:0] req_coord_x,
   input logic                                  rsp_valid,
   input logic [bts_pkg::TEXEL_BITS-1:0]        rsp_pixel
);
   import bts_pkg::*;

   // Every sample item gives a result.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_SAMPLE) |-> ##5 rsp_valid)
      else $error("sample item produced no result");

   // Write items never produce a result.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_WRITE) |-> ##5 !rsp_valid)
      else $error("write item produced a result");

   // A result always traces back to a sample item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy && req_opcode == OP_SAMPLE, 5))
      else $error("result without a sample item");

   // A negative x coordinate is outside the texture and reads as zero.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_opcode == OP_SAMPLE && req_coord_x[COORD_BITS-1])
         |-> ##5 (rsp_pixel == '0))
      else $error("sample outside the texture gave a nonzero pixel");

   // Reset flushes the pipeline.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result right after reset");

endmodule

bind bilinear_texel_sampler_core bts_checker u_checker (.*);
